// File: rtl/core/opbb_pkg.sv
// ----------------------------------------------------------------------------
// opbb_pkg
// Shared constants, types and helpers of the opaque pixel bounding box.
// ----------------------------------------------------------------------------
`default_nettype none

package opbb_pkg;

    // Largest frame side the column memory covers.
    localparam int MAX_FRAME_SIDE = 1024;
    // Position width (0 .. side-1) and side width (1 .. side).
    localparam int POS_W  = $clog2(MAX_FRAME_SIDE);
    localparam int SIDE_W = POS_W + 1;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [SIDE_W-1:0] FRAME_WIDTH_RESET  = SIDE_W'(64);
    localparam logic [SIDE_W-1:0] FRAME_HEIGHT_RESET = SIDE_W'(64);

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // Bounding box snapshot taken on the final pixel.
    typedef struct packed {
        logic [SIDE_W-1:0] min_x;
        logic [SIDE_W-1:0] min_y;
        logic [POS_W-1:0]  max_x;
        logic [POS_W-1:0]  max_y;
        logic [SIDE_W-1:0] side_w;
        logic [SIDE_W-1:0] side_h;
    } t_snap;

    // Crop rectangle.
    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
    } t_crop;

    // Map a programmed side into 1 .. MAX_FRAME_SIDE.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_FRAME_SIDE)) begin
            return SIDE_W'(MAX_FRAME_SIDE);
        end else begin
            return v;
        end
    endfunction

    // Pull the minimum back by the far margin, clamp into 0 .. side-1.
    function automatic logic [POS_W-1:0] crop_low(
        input logic [SIDE_W-1:0] mn,
        input logic [POS_W-1:0]  mx,
        input logic [SIDE_W-1:0] side
    );
        logic signed [SIDE_W+1:0] lo;
        logic signed [SIDE_W+1:0] top;
        lo  = $signed({2'b00, mn}) + $signed({3'b000, mx}) - $signed({2'b00, side});
        top = $signed({2'b00, side - SIDE_W'(1)});
        if (lo[SIDE_W+1]) begin
            lo = '0;
        end else if (lo > top) begin
            lo = top;
        end
        return lo[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/opaque_pixel_bounding_box.sv
// Throughput: one pixel per cycle over column and frame ends, unless a final pixel
// finds the crop stage full. The crop passes stage 1, the snapshot register and the
// output register. The column memory is read at transfer, written back as stage 1
// retires; a same-row hit (one-pixel-high frames) is forwarded from the write port.
// Reset: synchronous, active low; sides return to 64, tracking restarts at (0, 0).
// The column memory is not cleared: column 0 never uses it.
// ----------------------------------------------------------------------------
// opaque_pixel_bounding_box
// Streams animation pixels column by column and reports the crop rectangle
// around the pixels that sit in a mostly opaque 2x2 window.
// ----------------------------------------------------------------------------
`default_nettype none

module opaque_pixel_bounding_box (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // APB-style configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [opbb_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [opbb_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [opbb_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // pixel input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [31:0]                       i_pixel_argb,
    input  wire logic                              i_final_pixel,
    // crop output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [opbb_pkg::POS_W-1:0]        o_crop_x,
    output logic      [opbb_pkg::POS_W-1:0]        o_crop_y,
    output logic      [opbb_pkg::SIDE_W-1:0]       o_crop_width,
    output logic      [opbb_pkg::SIDE_W-1:0]       o_crop_height
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [opbb_pkg::SIDE_W-1:0] r_frame_width;
    logic [opbb_pkg::SIDE_W-1:0] r_frame_height;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= opbb_pkg::FRAME_WIDTH_RESET;
            r_frame_height <= opbb_pkg::FRAME_HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                opbb_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[opbb_pkg::SIDE_W-1:0];
                end
                opbb_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[opbb_pkg::SIDE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            opbb_pkg::REG_FRAME_WIDTH: begin
                prdata = opbb_pkg::CFG_DATA_W'(r_frame_width);
            end
            opbb_pkg::REG_FRAME_HEIGHT: begin
                prdata = opbb_pkg::CFG_DATA_W'(r_frame_height);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // Effective sides, clamped into 1 .. MAX_FRAME_SIDE.
    logic [opbb_pkg::SIDE_W-1:0] side_w;
    logic [opbb_pkg::SIDE_W-1:0] side_h;

    assign side_w = opbb_pkg::eff_side(r_frame_width);
    assign side_h = opbb_pkg::eff_side(r_frame_height);

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic in_xfer;
    logic s1_go;
    logic snap_valid;
    logic snap_ready;

    logic                       r_s1_valid;
    logic                       r_s1_cur;
    logic                       r_s1_fin;
    logic                       r_s1_wrap;
    logic [opbb_pkg::POS_W-1:0] r_s1_x;
    logic [opbb_pkg::POS_W-1:0] r_s1_y;
    logic                       r_s1_fwd;
    logic                       r_s1_fwd_val;

    // Stage 1 retires unless its final pixel finds the crop stage full.
    assign snap_valid = r_s1_valid && r_s1_fin;
    assign s1_go      = r_s1_valid && (!r_s1_fin || snap_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_xfer    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Stage 0: position counters and column memory read
    // ------------------------------------------------------------------
    logic [opbb_pkg::POS_W-1:0] r_x;
    logic [opbb_pkg::POS_W-1:0] r_y;
    logic                       wrap_y;
    logic                       wrap_x;
    logic                       cur;
    logic                       fwd_hit;

    assign cur    = (i_pixel_argb != '0);
    assign wrap_y = ({1'b0, r_y} + opbb_pkg::SIDE_W'(1)) >= side_h;
    assign wrap_x = ({1'b0, r_x} + opbb_pkg::SIDE_W'(1)) >= side_w;
    // Same row being written back this cycle: the read sees the old word.
    assign fwd_hit = s1_go && (r_s1_y == r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (in_xfer) begin
            if (i_final_pixel) begin
                // restart tracking at the origin
                r_x <= '0;
                r_y <= '0;
            end else if (wrap_y) begin
                r_y <= '0;
                r_x <= wrap_x ? '0 : r_x + opbb_pkg::POS_W'(1);
            end else begin
                r_y <= r_y + opbb_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_s1_cur     <= cur;
            r_s1_fin     <= i_final_pixel;
            r_s1_wrap    <= wrap_y;
            r_s1_x       <= r_x;
            r_s1_y       <= r_y;
            r_s1_fwd     <= fwd_hit;
            r_s1_fwd_val <= r_s1_cur;
        end
    end

    // Opacity of the previous column, one bit per row.
    logic col_rd_data;

    opbb_ram #(
        .WIDTH (1),
        .DEPTH (opbb_pkg::MAX_FRAME_SIDE)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_y),
        .i_wr_data (r_s1_cur),
        .i_rd_en   (in_xfer),
        .i_rd_addr (r_y),
        .o_rd_data (col_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: 2x2 window test, bounding box update, write back
    // ------------------------------------------------------------------
    logic                        r_above;
    logic                        r_upleft;
    logic [opbb_pkg::SIDE_W-1:0] r_min_x;
    logic [opbb_pkg::SIDE_W-1:0] r_min_y;
    logic [opbb_pkg::POS_W-1:0]  r_max_x;
    logic [opbb_pkg::POS_W-1:0]  r_max_y;
    logic                        r_any;

    logic                        left_raw;
    logic                        left;
    logic                        up;
    logic                        upleft;
    logic [1:0]                  nbr_cnt;
    logic                        counted;
    logic [opbb_pkg::SIDE_W-1:0] n_min_x;
    logic [opbb_pkg::SIDE_W-1:0] n_min_y;
    logic [opbb_pkg::POS_W-1:0]  n_max_x;
    logic [opbb_pkg::POS_W-1:0]  n_max_y;
    logic                        n_any;
    opbb_pkg::t_snap             snap;

    assign left_raw = r_s1_fwd ? r_s1_fwd_val : col_rd_data;
    // Neighbors outside the frame count as transparent.
    assign left     = (r_s1_x != '0) && left_raw;
    assign up       = (r_s1_y != '0) && r_above;
    assign upleft   = (r_s1_x != '0) && (r_s1_y != '0) && r_upleft;
    assign nbr_cnt  = 2'(left) + 2'(up) + 2'(upleft);
    // Opaque plus at least two opaque neighbors.
    assign counted  = r_s1_cur && (nbr_cnt >= 2'd2);

    always_comb begin
        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        n_any   = r_any || counted;
        if (counted) begin
            if ({1'b0, r_s1_x} < r_min_x) begin
                n_min_x = {1'b0, r_s1_x};
            end
            if ({1'b0, r_s1_y} < r_min_y) begin
                n_min_y = {1'b0, r_s1_y};
            end
            if (r_s1_x > r_max_x) begin
                n_max_x = r_s1_x;
            end
            if (r_s1_y > r_max_y) begin
                n_max_y = r_s1_y;
            end
        end
    end

    // With nothing counted the box collapses to the whole frame.
    always_comb begin
        snap.min_x  = n_any ? n_min_x : side_w;
        snap.min_y  = n_any ? n_min_y : side_h;
        snap.max_x  = n_max_x;
        snap.max_y  = n_max_y;
        snap.side_w = side_w;
        snap.side_h = side_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above  <= 1'b0;
            r_upleft <= 1'b0;
            r_min_x  <= opbb_pkg::eff_side(opbb_pkg::FRAME_WIDTH_RESET);
            r_min_y  <= opbb_pkg::eff_side(opbb_pkg::FRAME_HEIGHT_RESET);
            r_max_x  <= '0;
            r_max_y  <= '0;
            r_any    <= 1'b0;
        end else if (s1_go) begin
            if (r_s1_fin) begin
                // drop the box, start fresh for the next animation
                r_above  <= 1'b0;
                r_upleft <= 1'b0;
                r_min_x  <= side_w;
                r_min_y  <= side_h;
                r_max_x  <= '0;
                r_max_y  <= '0;
                r_any    <= 1'b0;
            end else begin
                r_above  <= r_s1_wrap ? 1'b0 : r_s1_cur;
                r_upleft <= left_raw;
                r_min_x  <= n_min_x;
                r_min_y  <= n_min_y;
                r_max_x  <= n_max_x;
                r_max_y  <= n_max_y;
                r_any    <= n_any;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: crop rectangle and output register
    // ------------------------------------------------------------------
    opbb_pkg::t_crop crop;

    opbb_crop u_crop (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_crop       (crop)
    );

    assign o_crop_x      = crop.x;
    assign o_crop_y      = crop.y;
    assign o_crop_width  = crop.width;
    assign o_crop_height = crop.height;

endmodule

`default_nettype wire

// File: rtl/core/opbb_ram.sv
// ----------------------------------------------------------------------------
// opbb_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module opbb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read returns the old word when both ports hit the same address.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/opbb_crop.sv
// ----------------------------------------------------------------------------
// opbb_crop
// Turns a bounding box snapshot into a crop rectangle; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module opbb_crop (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_snap_valid,
    output logic                 o_snap_ready,
    input  wire opbb_pkg::t_snap i_snap,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output opbb_pkg::t_crop      o_crop
);

    logic            r_snap_valid;
    opbb_pkg::t_snap r_snap;
    logic            r_out_valid;
    opbb_pkg::t_crop r_out;

    logic            move;
    logic            snap_take;
    opbb_pkg::t_crop n_out;

    assign move         = r_snap_valid && (!r_out_valid || i_ready);
    assign o_snap_ready = !r_snap_valid || move;
    assign snap_take    = i_snap_valid && o_snap_ready;

    always_comb begin
        n_out.x      = opbb_pkg::crop_low(r_snap.min_x, r_snap.max_x, r_snap.side_w);
        n_out.y      = opbb_pkg::crop_low(r_snap.min_y, r_snap.max_y, r_snap.side_h);
        n_out.width  = r_snap.side_w - {1'b0, n_out.x};
        n_out.height = r_snap.side_h - {1'b0, n_out.y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (snap_take) begin
                r_snap_valid <= 1'b1;
            end else if (move) begin
                r_snap_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (snap_take) begin
            r_snap <= i_snap;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_crop  = r_out;

endmodule

`default_nettype wire

// File: tb/opaque_pixel_bounding_box_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opaque_pixel_bounding_box_tb
// Self-checking bench for the crop rectangle finder. Pixel streams are pushed
// through the valid/ready input with bursty gaps while the crop output stalls
// on its own pattern. A cycle-free model of the sliding 2x2 window, the column
// memory and the min/max tracking predicts every crop rectangle, and each
// transfer on the output is checked field by field against the oldest one.
// ----------------------------------------------------------------------------

module opaque_pixel_bounding_box_tb;

    import opbb_pkg::*;

    // Bench timing and stimulus sizes.
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 20;
    localparam int MAX_GAP          = 9;
    localparam int MAX_BURST        = 64;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PRESSURE_PIXELS  = 60;
    localparam int RANDOM_PIXELS    = 900;
    localparam int SWEEP_SIDE       = 128;      // long side of the tall and wide sweeps
    localparam int REG_STRIDE       = 4;        // byte distance between registers
    localparam int TIMEOUT_NS       = 2_000_000;

    // Three opaque pixels on the diagonal corner of a 3x3 frame: the bottom-right
    // pixel sees exactly three of four, its left neighbor only two.
    localparam logic [8:0] CORNER_MASK = 9'b1_0011_0000;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_MOSTLY,
        READY_RARELY
    } t_ready_mode;

    // ------------------------------------------------------------------------
    // Crop rectangle predictor and store of crops still due
    // ------------------------------------------------------------------------
    class crop_tracker;
        localparam int MIN_OPAQUE   = 3;
        localparam int REPORT_LIMIT = 10;

        logic [SIDE_W-1:0] raw_width;
        logic [SIDE_W-1:0] raw_height;
        int                col_x;
        int                row_y;
        bit                col_opaque [MAX_FRAME_SIDE];
        bit                above_opaque;
        bit                upleft_opaque;
        int                min_x;
        int                min_y;
        int                max_x;
        int                max_y;
        bit                any_hit;
        t_crop             crops_due [$];
        int                mismatches;

        function new();
            raw_width     = FRAME_WIDTH_RESET;
            raw_height    = FRAME_HEIGHT_RESET;
            mismatches    = 0;
            restart();
        endfunction

        // Sides outside 1..MAX_FRAME_SIDE are pulled back to the nearest end.
        function int usable_side(logic [SIDE_W-1:0] raw);
            if (raw == '0) begin
                return 1;
            end
            if (int'(raw) > MAX_FRAME_SIDE) begin
                return MAX_FRAME_SIDE;
            end
            return int'(raw);
        endfunction

        function int width_now();
            return usable_side(raw_width);
        endfunction

        function int height_now();
            return usable_side(raw_height);
        endfunction

        function void restart();
            col_x         = 0;
            row_y         = 0;
            above_opaque  = 1'b0;
            upleft_opaque = 1'b0;
            min_x         = width_now();
            min_y         = height_now();
            max_x         = 0;
            max_y         = 0;
            any_hit       = 1'b0;
        endfunction

        function void set_side(t_reg_idx idx, logic [SIDE_W-1:0] value);
            if (idx == REG_FRAME_WIDTH) begin
                raw_width = value;
            end else begin
                raw_height = value;
            end
        endfunction

        // Pull the low edge back by the far margin, keep it inside the frame.
        function int crop_edge(int lowest, int highest, int side);
            int edge_pos;
            edge_pos = lowest + highest - side;
            if (edge_pos < 0) begin
                edge_pos = 0;
            end
            if (edge_pos > side - 1) begin
                edge_pos = side - 1;
            end
            return edge_pos;
        endfunction

        // Advance the window by one accepted pixel; queue a crop on the final one.
        function void take_pixel(logic [31:0] argb, logic is_final);
            int    w;
            int    h;
            int    x;
            int    y;
            int    hits;
            int    lo_x;
            int    lo_y;
            bit    cur;
            bit    left_raw;
            bit    left;
            bit    up;
            bit    upleft;
            t_crop crop;

            w        = width_now();
            h        = height_now();
            x        = col_x;
            y        = row_y;
            cur      = (argb != '0);
            left_raw = col_opaque[y];
            left     = (x > 0) ? left_raw : 1'b0;
            up       = (y > 0) ? above_opaque : 1'b0;
            upleft   = (x > 0 && y > 0) ? upleft_opaque : 1'b0;
            hits     = int'(cur) + int'(left) + int'(up) + int'(upleft);

            if (cur && hits >= MIN_OPAQUE) begin
                if (x < min_x) min_x = x;
                if (x > max_x) max_x = x;
                if (y < min_y) min_y = y;
                if (y > max_y) max_y = y;
                any_hit = 1'b1;
            end

            upleft_opaque = left_raw;
            col_opaque[y] = cur;
            above_opaque  = cur;

            if (y + 1 >= h) begin
                row_y        = 0;
                above_opaque = 1'b0;
                col_x        = (x + 1 >= w) ? 0 : x + 1;
            end else begin
                row_y = y + 1;
            end

            if (is_final) begin
                // With nothing counted the rectangle covers the whole frame.
                lo_x        = crop_edge(any_hit ? min_x : w, max_x, w);
                lo_y        = crop_edge(any_hit ? min_y : h, max_y, h);
                crop.x      = POS_W'(lo_x);
                crop.y      = POS_W'(lo_y);
                crop.width  = SIDE_W'(w - lo_x);
                crop.height = SIDE_W'(h - lo_y);
                crops_due.insert(crops_due.size(), crop);
                restart();
            end
        endfunction

        function void check_crop(t_crop got);
            t_crop want;
            if (crops_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected crop x=%0d y=%0d w=%0d h=%0d",
                             $realtime, got.x, got.y, got.width, got.height);
                end
                return;
            end
            want = crops_due.pop_front();
            if (got.x !== want.x || got.y !== want.y ||
                got.width !== want.width || got.height !== want.height) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] crop mismatch: expected x=%0d y=%0d w=%0d h=%0d,",
                             $realtime, want.x, want.y, want.width, want.height,
                             " got x=%0d y=%0d w=%0d h=%0d",
                             got.x, got.y, got.width, got.height);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic [31:0]             pixel_argb;
    logic                    final_pixel;
    logic                    out_valid;
    logic                    out_ready;
    logic [POS_W-1:0]        crop_x;
    logic [POS_W-1:0]        crop_y;
    logic [SIDE_W-1:0]       crop_width;
    logic [SIDE_W-1:0]       crop_height;

    crop_tracker board;
    int          burst_left;
    int          pixels_sent;
    int          hold_off_requests;

    opaque_pixel_bounding_box dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_pixel_argb  (pixel_argb),
        .i_final_pixel (final_pixel),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_crop_x      (crop_x),
        .o_crop_y      (crop_y),
        .o_crop_width  (crop_width),
        .o_crop_height (crop_height)
    );

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run; the slowest correct run stays far below this.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Color word, zero unless opaque: all ones, a walking one, or anything nonzero random.
    function automatic logic [31:0] pixel_word(bit opaque);
        logic [31:0] word;
        if (!opaque) begin
            return '0;
        end
        case ($urandom_range(0, 3))
            0:       word = '1;
            1:       word = 32'h1 << $urandom_range(0, 31);
            default: word = $urandom;
        endcase
        return (word == '0) ? 32'h1 : word;
    endfunction

    // Raw side value: mostly tiny frames, sometimes mid-size, sometimes zero.
    function automatic logic [SIDE_W-1:0] random_side();
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return SIDE_W'($urandom_range(9, 24));
            default: return SIDE_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Offer one pixel and hold it until the transfer; bursts and gaps are drawn
    // here so that idle cycles land anywhere in a frame.
    task automatic send_pixel(input logic [31:0] word, input logic is_final);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, MAX_BURST);
        end
        burst_left--;
        in_valid    <= 1'b1;
        pixel_argb  <= word;
        final_pixel <= is_final;
        // Inputs only move at rising edges, so the falling edge shows whether
        // the next rising edge completes the transfer.
        do begin
            @(negedge clk);
        end while (!in_ready);
        @(posedge clk);
        board.take_pixel(word, is_final);
        pixels_sent++;
    endtask

    // Drop valid, wait for every crop still due, then let the pipeline drain.
    task automatic idle_wait();
        in_valid <= 1'b0;
        while (board.crops_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // that closes the access. Bits above the register width carry noise.
    task automatic program_side(input t_reg_idx idx, input logic [SIDE_W-1:0] value);
        logic [CFG_DATA_W-1:0] word;
        word               = $urandom;
        word[SIDE_W-1:0]   = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * REG_STRIDE);
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do begin
            @(negedge clk);
        end while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_side(idx, value);
    endtask

    // Stream whole frames at the current sides with a dense rectangle of
    // content. A rough stream either ends early on a final pixel in the middle
    // of a frame or changes both sides partway through.
    task automatic stream_frames(input int frames, input int x0, input int x1,
                                 input int y0, input int y1, input int dens_in,
                                 input int dens_out, input bit rough);
        int total;
        int cut;
        int shift_at;
        int i;
        bit in_box;
        total    = board.width_now() * board.height_now() * frames;
        cut      = total - 1;
        shift_at = -1;
        if (rough) begin
            if ($urandom_range(0, 1) == 0) begin
                cut = $urandom_range(0, total - 1);
            end else begin
                shift_at = $urandom_range(0, total - 1);
            end
        end
        for (i = 0; i <= cut; i++) begin
            if (i == shift_at) begin
                idle_wait();
                program_side(REG_FRAME_WIDTH, random_side());
                program_side(REG_FRAME_HEIGHT, random_side());
            end
            in_box = board.col_x >= x0 && board.col_x <= x1 &&
                     board.row_y >= y0 && board.row_y <= y1;
            send_pixel(pixel_word($urandom_range(0, 99) < (in_box ? dens_in : dens_out)),
                       i == cut);
        end
    endtask

    // ------------------------------------------------------------------------
    // Crop receiver: switch between stall patterns, and honor a long hold-off
    // when the stimulus asks for one.
    // ------------------------------------------------------------------------
    initial begin
        t_ready_mode mode;
        int          segment_left;
        int          hold_left;
        int          holds_seen;
        mode         = READY_ALWAYS;
        segment_left = 0;
        hold_left    = 0;
        holds_seen   = 0;
        out_ready   <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_requests != holds_seen) begin
                holds_seen = hold_off_requests;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (segment_left == 0) begin
                    mode         = t_ready_mode'($urandom_range(0, 3));
                    segment_left = $urandom_range(20, 200);
                end
                segment_left--;
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Crop monitor: sample at the falling edge, where valid and ready are
    // settled for the rising edge that completes the transfer.
    // ------------------------------------------------------------------------
    initial begin
        t_crop got;
        forever begin
            @(negedge clk);
            if (out_valid && out_ready) begin
                got.x      = crop_x;
                got.y      = crop_y;
                got.width  = crop_width;
                got.height = crop_height;
                board.check_crop(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int w;
        int h;
        int frames;
        int x0;
        int x1;
        int y0;
        int y1;
        int i;
        bit pressure_done;

        board             = new();
        burst_left        = 0;
        pixels_sent       = 0;
        hold_off_requests = 0;
        pressure_done     = 1'b0;

        // Drive every input to a known value, hold reset, then release it.
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        pixel_argb  <= '0;
        final_pixel <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sides (64x64): a final pixel early in column 0, nothing counted,
        // so the crop is the whole frame.
        send_pixel(32'hFFFF_FFFF, 1'b0);
        send_pixel(32'h0000_0001, 1'b0);
        send_pixel(32'h8000_0000, 1'b1);

        // Zero sides act as one: a single-pixel animation.
        idle_wait();
        program_side(REG_FRAME_WIDTH, '0);
        program_side(REG_FRAME_HEIGHT, '0);
        send_pixel(32'h1234_5678, 1'b1);

        // 3x3 frame: one pixel counts on exactly three of four, one misses on two.
        idle_wait();
        program_side(REG_FRAME_WIDTH, SIDE_W'(3));
        program_side(REG_FRAME_HEIGHT, SIDE_W'(3));
        for (i = 0; i < 9; i++) begin
            send_pixel(pixel_word(CORNER_MASK[i]), i == 8);
        end

        // Oversized sides clamp to the largest frame; end early again.
        idle_wait();
        program_side(REG_FRAME_WIDTH, '1);
        program_side(REG_FRAME_HEIGHT, SIDE_W'(MAX_FRAME_SIDE + 1));
        send_pixel(32'h0, 1'b0);
        send_pixel(32'hFFFF_FFFF, 1'b1);

        // Tall sweep: content in the last rows. This also writes every row of
        // the column memory that a later side change can reach, so such reads
        // see defined entries.
        idle_wait();
        program_side(REG_FRAME_WIDTH, SIDE_W'(2));
        program_side(REG_FRAME_HEIGHT, SIDE_W'(SWEEP_SIDE));
        stream_frames(1, 0, 1, SWEEP_SIDE - 24, SWEEP_SIDE - 1, 100, 0, 1'b0);

        // Wide sweep: content in the last columns.
        idle_wait();
        program_side(REG_FRAME_WIDTH, SIDE_W'(SWEEP_SIDE));
        program_side(REG_FRAME_HEIGHT, SIDE_W'(2));
        stream_frames(1, SWEEP_SIDE - 24, SWEEP_SIDE - 1, 0, 1, 100, 0, 1'b0);

        // Random animations: mostly well-formed, some cut short or resized.
        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 1) == 0) begin
                idle_wait();
                program_side(REG_FRAME_WIDTH, random_side());
                program_side(REG_FRAME_HEIGHT, random_side());
            end
            w      = board.width_now();
            h      = board.height_now();
            frames = (w > 8 || h > 8) ? 1 : $urandom_range(1, 3);
            x0     = $urandom_range(0, w - 1);
            x1     = $urandom_range(x0, w - 1);
            y0     = $urandom_range(0, h - 1);
            y1     = $urandom_range(y0, h - 1);
            stream_frames(frames, x0, x1, y0, y1, $urandom_range(50, 100),
                          $urandom_range(0, 30), $urandom_range(0, 4) == 0);

            // Hold the receiver off and pile up crops with a final on every
            // pixel so that the input stalls; then pause until all have drained.
            if (!pressure_done && pixels_sent >= RANDOM_PIXELS / 2) begin
                hold_off_requests++;
                repeat (PRESSURE_PIXELS) begin
                    send_pixel(pixel_word($urandom_range(0, 1) == 1), 1'b1);
                end
                idle_wait();
                pressure_done = 1'b1;
            end
        end

        // Drain and give a stray crop time to show up.
        idle_wait();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.crops_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
